[rtl/tbs_pkg.sv]
// Package for the token bucket shaper: sizes, the request kind and reset values.
// Used by tbs_ram users, token_bucket_shaper and tbs_checker. Depends on nothing.
`default_nettype none

package tbs_pkg;

   // Waiting queue geometry.
   localparam int QUEUE_DEPTH = 64;
   localparam int PTR_WIDTH   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_WIDTH   = $clog2(QUEUE_DEPTH + 1);

   // Field widths on the ports.
   localparam int TOKEN_WIDTH    = 16;
   localparam int TAG_PORT_WIDTH = 16;

   // Tag bits kept in the queue: the low TAG_WIDTH bits of the port.
   localparam int TAG_WIDTH      = 16;
   localparam int KEEP_TAG_WIDTH = (TAG_WIDTH < TAG_PORT_WIDTH) ? TAG_WIDTH : TAG_PORT_WIDTH;
   localparam int ENTRY_WIDTH    = KEEP_TAG_WIDTH + TOKEN_WIDTH;

   localparam logic [TOKEN_WIDTH-1:0] BUCKET_DEPTH_RESET = TOKEN_WIDTH'(10);

   // Kind of request beat.
   typedef enum logic {
      FUNC_TICK    = 1'b0,
      FUNC_ARRIVAL = 1'b1
   } func_type;

endpackage

`default_nettype wire

[rtl/token_bucket_shaper.sv]
// Top level of the token bucket shaper: token counter, queue pointers and control.
// Depends on tbs_pkg and on tbs_ram, which holds the waiting queue.
`default_nettype none

// How the block is used
// ---------------------
// Requests arrive as beats on the req_ channel. A beat is either a token tick
// (req_func = 0), which adds one token to the bucket, or a packet arrival
// (req_func = 1) carrying a tag and the number of tokens it needs. Every
// request beat produces exactly one result beat on the rsp_ channel, in order,
// telling whether the packet was dropped, queued or released, whether a token
// was discarded, the tag of any released packet and the token count left.
// The bucket depth is written through the csr_ channel, which is always ready;
// it should only be written while no request is outstanding.
// Each request is accepted in ST_IDLE, while the waiting queue memory reads
// the current head entry, and is acted on in ST_EXEC; the registered read of
// that memory sets this, and no new request is accepted until the last one
// has been acted on. The result sits in an output register, and a
// new request may be accepted while it waits; if the receiver stalls, that
// request is held until the output register drains. Synchronous reset empties
// the queue, zeroes the token count, restores a bucket depth of ten and drops
// any result that has not been taken.

module token_bucket_shaper (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // Request channel.
   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire logic                               req_func,
   input  wire logic [tbs_pkg::TAG_PORT_WIDTH-1:0] req_packet_tag,
   input  wire logic [tbs_pkg::TOKEN_WIDTH-1:0]    req_tokens_needed,
   // Result channel.
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output logic                                    rsp_packet_dropped,
   output logic                                    rsp_packet_queued,
   output logic                                    rsp_queue_overflow,
   output logic                                    rsp_token_dropped,
   output logic                                    rsp_released,
   output logic      [tbs_pkg::TAG_PORT_WIDTH-1:0] rsp_released_tag,
   output logic      [tbs_pkg::TOKEN_WIDTH-1:0]    rsp_tokens_left,
   // Configuration channel.
   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic [tbs_pkg::TOKEN_WIDTH-1:0]    csr_bucket_depth
);

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } state_type;

   state_type state_ff;

   // Captured request.
   tbs_pkg::func_type                        req_func_ff;
   logic [tbs_pkg::KEEP_TAG_WIDTH-1:0]       req_tag_ff;
   logic [tbs_pkg::TOKEN_WIDTH-1:0]          req_need_ff;

   // Architectural state.
   logic [tbs_pkg::TOKEN_WIDTH-1:0]          depth_ff;
   logic [tbs_pkg::TOKEN_WIDTH-1:0]          token_ff, token_in;
   logic [tbs_pkg::PTR_WIDTH-1:0]            head_ff, head_in;
   logic [tbs_pkg::PTR_WIDTH-1:0]            tail_ff, tail_in;
   logic [tbs_pkg::CNT_WIDTH-1:0]            count_ff, count_in;

   // Result register.
   logic                                     rsp_valid_ff, rsp_valid_in;
   logic                                     dropped_ff, dropped_in;
   logic                                     queued_ff, queued_in;
   logic                                     overflow_ff, overflow_in;
   logic                                     tok_drop_ff, tok_drop_in;
   logic                                     released_ff, released_in;
   logic [tbs_pkg::KEEP_TAG_WIDTH-1:0]       rel_tag_ff, rel_tag_in;

   // Queue memory interface.
   logic                                     push;
   logic [tbs_pkg::ENTRY_WIDTH-1:0]          head_entry;
   logic [tbs_pkg::KEEP_TAG_WIDTH-1:0]       head_tag;
   logic [tbs_pkg::TOKEN_WIDTH-1:0]          head_need;
   logic [tbs_pkg::TOKEN_WIDTH-1:0]          tick_tokens;
   logic                                     queue_empty;
   logic                                     queue_full;
   logic                                     commit;

   // The memory reads the head entry every cycle. A request is acted on in
   // ST_EXEC, after it was accepted (a stall may hold it there), and no push or
   // pop happens in between, so the read data always matches the head when used.
   tbs_ram #(
      .WIDTH (tbs_pkg::ENTRY_WIDTH),
      .DEPTH (tbs_pkg::QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .wr_en   (push),
      .wr_addr (tail_ff),
      .wr_data ({req_tag_ff, req_need_ff}),
      .rd_addr (head_ff),
      .rd_data (head_entry)
   );

   assign head_tag  = head_entry[tbs_pkg::ENTRY_WIDTH-1 -: tbs_pkg::KEEP_TAG_WIDTH];
   assign head_need = head_entry[tbs_pkg::TOKEN_WIDTH-1:0];

   assign queue_empty = (count_ff == '0);
   assign queue_full  = (count_ff == tbs_pkg::CNT_WIDTH'(tbs_pkg::QUEUE_DEPTH));

   // The request is acted on once the output register is free or is draining.
   assign commit = (state_ff == ST_EXEC) && (!rsp_valid_ff || rsp_ready);

   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;

   always_comb begin
      token_in    = token_ff;
      head_in     = head_ff;
      tail_in     = tail_ff;
      count_in    = count_ff;
      dropped_in  = 1'b0;
      queued_in   = 1'b0;
      overflow_in = 1'b0;
      tok_drop_in = 1'b0;
      released_in = 1'b0;
      rel_tag_in  = '0;
      push        = 1'b0;
      tick_tokens = token_ff;

      case (req_func_ff)
         tbs_pkg::FUNC_TICK: begin
            // Add the token unless the bucket is already at (or above) its depth.
            if (token_ff < depth_ff) begin
               tick_tokens = token_ff + 1'b1;
            end else begin
               tok_drop_in = 1'b1;
            end
            token_in = tick_tokens;
            // Only the head of the queue is considered, once per tick.
            if (!queue_empty && (head_need <= tick_tokens)) begin
               token_in    = tick_tokens - head_need;
               released_in = 1'b1;
               rel_tag_in  = head_tag;
               head_in     = (head_ff == tbs_pkg::PTR_WIDTH'(tbs_pkg::QUEUE_DEPTH - 1)) ?
                             '0 : head_ff + 1'b1;
               count_in    = count_ff - 1'b1;
            end
         end
         tbs_pkg::FUNC_ARRIVAL: begin
            if (req_need_ff > depth_ff) begin
               dropped_in = 1'b1;
            end else if (queue_empty && (req_need_ff <= token_ff)) begin
               token_in    = token_ff - req_need_ff;
               released_in = 1'b1;
               rel_tag_in  = req_tag_ff;
            end else if (queue_full) begin
               overflow_in = 1'b1;
            end else begin
               push      = commit;
               queued_in = 1'b1;
               tail_in   = (tail_ff == tbs_pkg::PTR_WIDTH'(tbs_pkg::QUEUE_DEPTH - 1)) ?
                           '0 : tail_ff + 1'b1;
               count_in  = count_ff + 1'b1;
            end
         end
         default: begin
            token_in = token_ff;
         end
      endcase

      if (commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         depth_ff     <= tbs_pkg::BUCKET_DEPTH_RESET;
         token_ff     <= '0;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;

         if (csr_valid && csr_ready) begin
            depth_ff <= csr_bucket_depth;
         end

         case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  req_func_ff <= tbs_pkg::func_type'(req_func);
                  req_tag_ff  <= req_packet_tag[tbs_pkg::KEEP_TAG_WIDTH-1:0];
                  req_need_ff <= req_tokens_needed;
                  state_ff    <= ST_EXEC;
               end
            end
            ST_EXEC: begin
               if (commit) begin
                  token_ff    <= token_in;
                  head_ff     <= head_in;
                  tail_ff     <= tail_in;
                  count_ff    <= count_in;
                  dropped_ff  <= dropped_in;
                  queued_ff   <= queued_in;
                  overflow_ff <= overflow_in;
                  tok_drop_ff <= tok_drop_in;
                  released_ff <= released_in;
                  rel_tag_ff  <= rel_tag_in;
                  state_ff    <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_packet_dropped = dropped_ff;
   assign rsp_packet_queued  = queued_ff;
   assign rsp_queue_overflow = overflow_ff;
   assign rsp_token_dropped  = tok_drop_ff;
   assign rsp_released       = released_ff;
   assign rsp_released_tag   = tbs_pkg::TAG_PORT_WIDTH'(rel_tag_ff);
   // The token count only changes when a result is loaded, so it always
   // matches the result being shown.
   assign rsp_tokens_left    = token_ff;

endmodule

`default_nettype wire

[rtl/tbs_ram.sv]
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies; contents are undefined until written.
`default_nettype none

module tbs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

[rtl/tbs_checker.sv]
// Port-level checks for token_bucket_shaper, attached with a bind statement.
// Depends on tbs_pkg for the field widths.
`default_nettype none

module tbs_checker (
   input wire logic                               clock,
   input wire logic                               reset,
   input wire logic                               rsp_valid,
   input wire logic                               rsp_ready,
   input wire logic                               rsp_packet_dropped,
   input wire logic                               rsp_packet_queued,
   input wire logic                               rsp_queue_overflow,
   input wire logic                               rsp_token_dropped,
   input wire logic                               rsp_released,
   input wire logic [tbs_pkg::TAG_PORT_WIDTH-1:0] rsp_released_tag,
   input wire logic [tbs_pkg::TOKEN_WIDTH-1:0]    rsp_tokens_left
);

   // A stalled result beat stays put.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_released_tag) &&
                                 $stable(rsp_tokens_left) && $stable(rsp_released))
      else $error("stalled result beat changed");

   // No result survives a reset.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result beat shown straight after reset");

   // A packet meets at most one fate per beat.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $onehot0({rsp_packet_dropped, rsp_packet_queued,
                              rsp_queue_overflow, rsp_released}))
      else $error("more than one packet outcome in one result beat");

   // A discarded token comes from a tick, which carries no arrival outcome.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_token_dropped |->
         !rsp_packet_dropped && !rsp_packet_queued && !rsp_queue_overflow)
      else $error("token discard flagged alongside an arrival outcome");

   // The released tag reads zero when nothing is released.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_released |-> rsp_released_tag == '0)
      else $error("released tag set without a release");

endmodule

bind token_bucket_shaper tbs_checker u_tbs_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_valid),
   .rsp_ready          (rsp_ready),
   .rsp_packet_dropped (rsp_packet_dropped),
   .rsp_packet_queued  (rsp_packet_queued),
   .rsp_queue_overflow (rsp_queue_overflow),
   .rsp_token_dropped  (rsp_token_dropped),
   .rsp_released       (rsp_released),
   .rsp_released_tag   (rsp_released_tag),
   .rsp_tokens_left    (rsp_tokens_left)
);

`default_nettype wire
